// File: sv/srr_pkg.sv
// Shared types, result codes and id helpers for the sequence reorder receiver.
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

   localparam int ID_W   = 16;
   localparam int TAG_W  = 16;
   localparam int LEN_W  = 16;
   localparam int KIND_W = 3;
   localparam int CNT_W  = 4;

   // At most this many stored packets drain behind one in-order delivery.
   localparam int DRAIN_MAX = 15;
   localparam int DRAIN_W   = 4;

   localparam logic [KIND_W-1:0] KIND_DELIVER  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STORED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RST_REQ  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RST_DONE = 3'd5;

   localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
   } slot_type;

   typedef enum logic [1:0] {
      SRC_ITEM = 2'd0,
      SRC_SLOT = 2'd1,
      SRC_NONE = 2'd2
   } src_type;

   // Step an id on by one over the full id space, skipping zero.
   function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] v);
      logic [ID_W-1:0] n;
      n = v + ID_W'(1);
      if (n == '0) begin
         n = ID_W'(1);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: sv/sequence_reorder_receiver_core.sv
// Reorder buffer for the receive side of a reliable datagram channel.
`timescale 1ns / 1ps
`default_nettype none

// Receive-side reorder buffer. Each request is either a channel reset or a
// data packet (sequence id, payload tag, length). A packet at the expected
// id is delivered, the expected id advances (wrapping, never zero) and the
// stored packets that are now in order follow as further deliver results;
// rsp_last marks the final result of a request, and every result of one
// request carries the expected id and ahead count as they stand after it.
// A packet ahead of the expected id is stored once if it lies within WINDOW
// and a slot is free, else window overflow is reported. Ids are 16 bits and
// wrap over the full 16-bit space. The slot store is a WINDOW-entry memory
// with one read port, searched by a single comparator that looks at one
// slot per cycle, so timing is set by that scan: a channel reset, and a
// reset request while no id is expected, skip the scan; every other
// request scans the store, and an in-order delivery scans it again for every
// packet drained behind it (each hit restarts the search for the next id,
// and each drained result needs one memory read). One request is handled
// at a time; req_stall stays high until the last result has been placed in
// the output register, which may still wait for the consumer while the next
// request is taken. csr_write_data sets zero tolerance and must only be
// written with the block idle.
module sequence_reorder_receiver_core #(
   parameter int WINDOW = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       csr_write_enable,
   input  wire logic                       csr_write_data,

   input  wire logic                       req_valid,
   output      logic                       req_stall,
   input  wire logic                       req_mode,
   input  wire logic [srr_pkg::ID_W-1:0]   req_packet_id,
   input  wire logic [srr_pkg::TAG_W-1:0]  req_payload_tag,
   input  wire logic [srr_pkg::LEN_W-1:0]  req_payload_length,

   output      logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   output      logic [srr_pkg::KIND_W-1:0] rsp_kind,
   output      logic [srr_pkg::ID_W-1:0]   rsp_out_id,
   output      logic [srr_pkg::TAG_W-1:0]  rsp_out_tag,
   output      logic [srr_pkg::LEN_W-1:0]  rsp_out_length,
   output      logic                       rsp_last,
   output      logic [srr_pkg::ID_W-1:0]   rsp_next_expected,
   output      logic [srr_pkg::CNT_W-1:0]  rsp_ahead_count
);

   import srr_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);
   localparam logic [IDX_W:0]   ISSUE_END = (IDX_W+1)'(WINDOW);
   localparam logic [ID_W-1:0]  WIN_DIST  = ID_W'(WINDOW);
   localparam logic [DRAIN_W-1:0] DRAIN_LIM = DRAIN_W'(DRAIN_MAX);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,   // wait for a request
      S_CLASS = 5'b00010,   // sort the request
      S_SCAN  = 5'b00100,   // walk the slot store with the comparator
      S_READ  = 5'b01000,   // fetch a drained slot
      S_PUT   = 5'b10000    // hand a result to the output register
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type            state_ff,   state_in;
   logic                 zt_ff,      zt_in;
   logic [ID_W-1:0]      exp_ff,     exp_in;
   logic [CNT_W-1:0]     cnt_ff,     cnt_in;
   logic [WINDOW-1:0]    valid_ff,   valid_in;

   logic                 mode_ff,    mode_in;
   slot_type             item_ff,    item_in;

   logic                 drain_ff,   drain_in;
   logic [IDX_W:0]       issue_ff,   issue_in;
   logic                 pend_ff,    pend_in;
   logic [IDX_W-1:0]     ridx_ff,    ridx_in;
   logic                 rvalid_ff,  rvalid_in;
   logic                 match_ff,   match_in;
   logic                 free_ff,    free_in;
   logic [IDX_W-1:0]     fidx_ff,    fidx_in;

   logic [DRAIN_W-1:0]   k_ff,       k_in;
   logic [DRAIN_W-1:0]   emit_ff,    emit_in;
   logic [IDX_W-1:0]     list_ff [DRAIN_MAX];
   logic                 list_we;

   logic [KIND_W-1:0]    kind_ff,    kind_in;
   src_type              src_ff,     src_in;

   logic                 ov_ff,      ov_in;
   logic [KIND_W-1:0]    okind_ff,   okind_in;
   slot_type             oslot_ff,   oslot_in;
   logic                 olast_ff,   olast_in;
   logic [ID_W-1:0]      oexp_ff,    oexp_in;
   logic [CNT_W-1:0]     ocnt_ff,    ocnt_in;

   // Slot memory ports
   slot_type             slot_mem [WINDOW];
   slot_type             rdata_ff;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;

   // ---------------------------------------------------------------------
   // Shared compare unit: one stored id against the search key per cycle
   // ---------------------------------------------------------------------
   logic [ID_W-1:0]      key;
   logic                 hit;
   logic [ID_W-1:0]      id_dist;
   logic                 ahead;
   logic                 accept;
   logic                 out_free;
   logic                 scan_done;

   assign key       = drain_ff ? exp_ff : item_ff.id;
   assign hit       = pend_ff && rvalid_ff && (rdata_ff.id == key);
   assign id_dist   = item_ff.id - exp_ff;
   assign ahead     = (id_dist != '0) && !id_dist[ID_W-1] && !match_ff;
   assign scan_done = (issue_ff == ISSUE_END) && !pend_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !ov_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      zt_in     = csr_write_enable ? csr_write_data : zt_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff;
      mode_in   = mode_ff;
      item_in   = item_ff;
      drain_in  = drain_ff;
      issue_in  = issue_ff;
      pend_in   = 1'b0;
      ridx_in   = ridx_ff;
      rvalid_in = rvalid_ff;
      match_in  = match_ff;
      free_in   = free_ff;
      fidx_in   = fidx_ff;
      k_in      = k_ff;
      emit_in   = emit_ff;
      list_we   = 1'b0;
      kind_in   = kind_ff;
      src_in    = src_ff;
      mem_re    = 1'b0;
      mem_raddr = issue_ff[IDX_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = fidx_ff;

      // drop the waiting result once taken
      ov_in     = ov_ff && rsp_stall;
      okind_in  = okind_ff;
      oslot_in  = oslot_ff;
      olast_in  = olast_ff;
      oexp_in   = oexp_ff;
      ocnt_in   = ocnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               item_in  = '{id: req_packet_id, tag: req_payload_tag,
                            len: req_payload_length};
               k_in     = '0;
               emit_in  = '0;
               state_in = S_CLASS;
            end
         end

         S_CLASS: begin
            issue_in = '0;
            match_in = 1'b0;
            free_in  = 1'b0;
            src_in   = SRC_ITEM;
            priority if (mode_ff) begin
               // channel reset: empty the store and start over
               valid_in = '0;
               exp_in   = '0;
               cnt_in   = '0;
               kind_in  = KIND_RST_DONE;
               src_in   = SRC_NONE;
               state_in = S_PUT;
            end else if (exp_ff == '0 && item_ff.id != '0) begin
               kind_in  = KIND_RST_REQ;
               state_in = S_PUT;
            end else if (item_ff.id == exp_ff) begin
               // in order: advance, then hunt for the following ids
               exp_in   = next_id(exp_ff);
               cnt_in   = '0;
               drain_in = 1'b1;
               kind_in  = KIND_DELIVER;
               state_in = S_SCAN;
            end else begin
               drain_in = 1'b0;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (drain_ff && hit) begin
               // take this slot out of the store, restart for the next id
               list_we          = 1'b1;
               k_in             = k_ff + DRAIN_W'(1);
               valid_in[ridx_ff] = 1'b0;
               exp_in           = next_id(exp_ff);
               issue_in         = '0;
               if (k_ff + DRAIN_W'(1) == DRAIN_LIM) begin
                  state_in = S_PUT;
               end
            end else if (scan_done) begin
               if (!drain_ff) begin
                  priority if (ahead) begin
                     if (id_dist < WIN_DIST && free_ff) begin
                        mem_we          = 1'b1;
                        valid_in[fidx_ff] = 1'b1;
                        cnt_in          = (cnt_ff == CNT_MAX) ? cnt_ff
                                                              : cnt_ff + CNT_W'(1);
                        kind_in         = KIND_STORED;
                     end else begin
                        kind_in = KIND_OVERFLOW;
                     end
                  end else if (item_ff.id == '0 && !zt_ff && exp_ff != ID_W'(1)) begin
                     kind_in = KIND_RST_REQ;
                  end else begin
                     kind_in = KIND_DROPPED;
                  end
               end
               state_in = S_PUT;
            end else begin
               if (!drain_ff && pend_ff) begin
                  if (hit) begin
                     match_in = 1'b1;
                  end
                  if (!rvalid_ff && !free_ff) begin
                     free_in = 1'b1;
                     fidx_in = ridx_ff;
                  end
               end
               if (issue_ff != ISSUE_END) begin
                  mem_re    = 1'b1;
                  pend_in   = 1'b1;
                  ridx_in   = issue_ff[IDX_W-1:0];
                  rvalid_in = valid_ff[issue_ff[IDX_W-1:0]];
                  issue_in  = issue_ff + (IDX_W+1)'(1);
               end
            end
         end

         S_READ: begin
            mem_re    = 1'b1;
            mem_raddr = list_ff[emit_ff];
            emit_in   = emit_ff + DRAIN_W'(1);
            src_in    = SRC_SLOT;
            state_in  = S_PUT;
         end

         S_PUT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = kind_ff;
               unique case (src_ff)
                  SRC_ITEM: oslot_in = item_ff;
                  SRC_SLOT: oslot_in = rdata_ff;
                  default:  oslot_in = '0;
               endcase
               olast_in = (emit_ff == k_ff);
               oexp_in  = exp_ff;
               ocnt_in  = cnt_ff;
               state_in = (emit_ff == k_ff) ? S_IDLE : S_READ;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         zt_ff    <= 1'b0;
         exp_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         zt_ff    <= zt_in;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      item_ff   <= item_in;
      drain_ff  <= drain_in;
      issue_ff  <= issue_in;
      ridx_ff   <= ridx_in;
      rvalid_ff <= rvalid_in;
      match_ff  <= match_in;
      free_ff   <= free_in;
      fidx_ff   <= fidx_in;
      k_ff      <= k_in;
      emit_ff   <= emit_in;
      kind_ff   <= kind_in;
      src_ff    <= src_in;
      okind_ff  <= okind_in;
      oslot_ff  <= oslot_in;
      olast_ff  <= olast_in;
      oexp_ff   <= oexp_in;
      ocnt_ff   <= ocnt_in;
      if (list_we) begin
         list_ff[k_ff] <= ridx_ff;
      end
   end

   // slot store: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= item_ff;
      end
      if (mem_re) begin
         rdata_ff <= slot_mem[mem_raddr];
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_kind          = okind_ff;
   assign rsp_out_id        = oslot_ff.id;
   assign rsp_out_tag       = oslot_ff.tag;
   assign rsp_out_length    = oslot_ff.len;
   assign rsp_last          = olast_ff;
   assign rsp_next_expected = oexp_ff;
   assign rsp_ahead_count   = ocnt_ff;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   a_accept_to_class: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CLASS)
      else $error("accepted request did not move to classification");

   a_store_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !valid_ff[mem_waddr])
      else $error("store overwrote an occupied slot");

   a_drain_key_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && drain_ff) |-> exp_ff != '0)
      else $error("drain searching for id zero");

   a_load_from_put: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !$past(ov_ff)) |-> $past(state_ff == S_PUT))
      else $error("result appeared outside the put step");

   a_drain_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && drain_ff) |-> k_ff != DRAIN_LIM)
      else $error("drain ran past its limit");

endmodule

`default_nettype wire

// File: bench/sequence_reorder_receiver_core_test.sv
// Self-checking testbench for the sequence reorder receiver core.
`timescale 1ns / 1ps

// The bench drives requests (channel resets and data packets) into the
// core and keeps its own model of the receive window. The model is stepped
// at the clock edge where each request is taken. It covers the expected id,
// the ahead counter, the sixteen-entry store and zero tolerance. It appends
// the responses that the request must cause to a queue. A checker takes
// every response that the consumer accepts and compares it field by field
// with the oldest queued one.
//
// Stimulus runs in two parts. A short directed part covers the edges of the
// scheme:
//   - reset request while no id is expected yet
//   - delivery of id zero
//   - storing ahead and dropping a repeat
//   - the window edge
//   - packets far behind
//   - draining stored packets
//   - the zero-id rules with tolerance off and on
//   - a full window drained in one run
// The random part is mostly runs of consecutive ids from the expected one,
// shuffled or reversed. Some runs have a gap, and stray ids are mixed in
// (random, zero, just past the window, just behind). Occasional channel
// resets restart the sequence. Sender gaps and consumer stalls change
// between phases.
module sequence_reorder_receiver_core_test;

   import srr_pkg::*;

   localparam int WINDOW = 16;
   // Watchdog limit on the whole run, kept well above the slowest correct run.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // Quiet spell after the last response, for any stray response to surface.
   localparam int SETTLE_CYCLES = 4 * (WINDOW + 3);
   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   id;
      logic [TAG_W-1:0]  tag;
      logic [LEN_W-1:0]  len;
      logic              last;
      logic [ID_W-1:0]   next_expected;
      logic [CNT_W-1:0]  ahead;
   } verdict_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic [ID_W-1:0]   req_packet_id = '0;
   logic [TAG_W-1:0]  req_payload_tag = '0;
   logic [LEN_W-1:0]  req_payload_length = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [ID_W-1:0]   rsp_out_id;
   logic [TAG_W-1:0]  rsp_out_tag;
   logic [LEN_W-1:0]  rsp_out_length;
   logic              rsp_last;
   logic [ID_W-1:0]   rsp_next_expected;
   logic [CNT_W-1:0]  rsp_ahead_count;

   // Window model.
   logic [ID_W-1:0]  exp_id = '0;
   logic [CNT_W-1:0] ahead_cnt = '0;
   bit               zero_tol = 1'b0;
   bit               slot_used [WINDOW];
   logic [ID_W-1:0]  slot_pkt_id [WINDOW];
   logic [TAG_W-1:0] slot_pkt_tag [WINDOW];
   logic [LEN_W-1:0] slot_pkt_len [WINDOW];

   verdict_type pending_verdicts [$];
   int          error_count = 0;
   int unsigned cycle_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   sequence_reorder_receiver_core #(
      .WINDOW(WINDOW)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_packet_id      (req_packet_id),
      .req_payload_tag    (req_payload_tag),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_out_length     (rsp_out_length),
      .rsp_last           (rsp_last),
      .rsp_next_expected  (rsp_next_expected),
      .rsp_ahead_count    (rsp_ahead_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Consumer back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sequence_reorder_receiver_core_test NOT OK");
         $finish;
      end
   end

   // Print one line per failure (up to a cap) and count every one.
   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s", $time, msg);
      end
   endtask

   // Advance an id by one, wrapping past the top and never landing on zero.
   function automatic logic [ID_W-1:0] step_id(input logic [ID_W-1:0] v);
      return (v == '1) ? ID_W'(1) : v + ID_W'(1);
   endfunction

   function automatic int find_stored(input logic [ID_W-1:0] id);
      for (int s = 0; s < WINDOW; s++) begin
         if (slot_used[s] && slot_pkt_id[s] == id) begin
            return s;
         end
      end
      return -1;
   endfunction

   function automatic verdict_type make_verdict(input logic [KIND_W-1:0] kind,
                                                input logic [ID_W-1:0] id,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [LEN_W-1:0] len);
      verdict_type v;
      v = '0;
      v.kind = kind;
      v.id = id;
      v.tag = tag;
      v.len = len;
      return v;
   endfunction

   // Step the window model by one accepted request.
   // Queue the responses that the request must cause.
   task automatic reorder_step(input bit mode, input logic [ID_W-1:0] id,
                               input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
      verdict_type step_out [$];
      verdict_type v;
      logic [ID_W-1:0] id_dist;
      int          hit;
      int          free_slot;
      if (mode) begin
         // Channel reset: clear the store and restart the sequence.
         for (int s = 0; s < WINDOW; s++) begin
            slot_used[s] = 1'b0;
         end
         exp_id = '0;
         ahead_cnt = '0;
         step_out.push_back(make_verdict(KIND_RST_DONE, '0, '0, '0));
      end else if (exp_id == '0 && id != '0) begin
         // Nothing expected yet and a nonzero id: reset request.
         step_out.push_back(make_verdict(KIND_RST_REQ, id, tag, len));
      end else if (id == exp_id) begin
         step_out.push_back(make_verdict(KIND_DELIVER, id, tag, len));
         exp_id = step_id(exp_id);
         hit = find_stored(exp_id);
         // Drain stored packets that are now in order, capped per request.
         while (hit >= 0 && step_out.size() <= DRAIN_MAX) begin
            step_out.push_back(make_verdict(KIND_DELIVER, slot_pkt_id[hit],
                                            slot_pkt_tag[hit], slot_pkt_len[hit]));
            slot_used[hit] = 1'b0;
            exp_id = step_id(exp_id);
            hit = find_stored(exp_id);
         end
         ahead_cnt = '0;
      end else begin
         id_dist = id - exp_id;
         if (id_dist != '0 && id_dist < 16'h8000 && find_stored(id) < 0) begin
            free_slot = -1;
            if (id_dist < WINDOW) begin
               for (int s = WINDOW - 1; s >= 0; s--) begin
                  if (!slot_used[s]) begin
                     free_slot = s;
                  end
               end
            end
            if (free_slot < 0) begin
               step_out.push_back(make_verdict(KIND_OVERFLOW, id, tag, len));
            end else begin
               slot_used[free_slot] = 1'b1;
               slot_pkt_id[free_slot] = id;
               slot_pkt_tag[free_slot] = tag;
               slot_pkt_len[free_slot] = len;
               if (ahead_cnt != CNT_MAX) begin
                  ahead_cnt++;
               end
               step_out.push_back(make_verdict(KIND_STORED, id, tag, len));
            end
         end else if (id == '0 && !zero_tol && exp_id != ID_W'(1)) begin
            step_out.push_back(make_verdict(KIND_RST_REQ, id, tag, len));
         end else begin
            step_out.push_back(make_verdict(KIND_DROPPED, id, tag, len));
         end
      end
      // Every response of a request reports the state after it.
      foreach (step_out[k]) begin
         v = step_out[k];
         v.next_expected = exp_id;
         v.ahead = ahead_cnt;
         v.last = (k == step_out.size() - 1);
         pending_verdicts.push_back(v);
      end
   endtask

   // Check each accepted response against the oldest queued one.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind %0d id 0x%0h",
                                      rsp_kind, rsp_out_id));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind got %0d expected %0d", rsp_kind, want.kind));
            if (rsp_out_id !== want.id)
               report_mismatch($sformatf("out_id got 0x%0h expected 0x%0h",
                                         rsp_out_id, want.id));
            if (rsp_out_tag !== want.tag)
               report_mismatch($sformatf("out_tag got 0x%0h expected 0x%0h",
                                         rsp_out_tag, want.tag));
            if (rsp_out_length !== want.len)
               report_mismatch($sformatf("out_length got 0x%0h expected 0x%0h",
                                         rsp_out_length, want.len));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %0d expected %0d", rsp_last, want.last));
            if (rsp_next_expected !== want.next_expected)
               report_mismatch($sformatf("next_expected got 0x%0h expected 0x%0h",
                                         rsp_next_expected, want.next_expected));
            if (rsp_ahead_count !== want.ahead)
               report_mismatch($sformatf("ahead_count got %0d expected %0d",
                                         rsp_ahead_count, want.ahead));
         end
      end
   end

   // Present one request and hold it until taken. Call only at a rising edge.
   // Valid stays high into the next request unless a sender gap is drawn.
   task automatic send_request(input bit mode, input logic [ID_W-1:0] id,
                               input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_packet_id <= id;
      req_payload_tag <= tag;
      req_payload_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reorder_step(mode, id, tag, len);
   endtask

   task automatic send_packet(input logic [ID_W-1:0] id);
      send_request(1'b0, id, TAG_W'($urandom), LEN_W'($urandom));
   endtask

   // Drop valid and hold until every queued response has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   // Write zero tolerance only once the core has gone quiet.
   task automatic set_zero_tolerance(input bit value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      zero_tol = value;
   endtask

   // An id off the in-order run: anything, zero, just past the window or behind.
   function automatic logic [ID_W-1:0] stray_id();
      case ($urandom_range(0, 3))
         0:       return ID_W'($urandom);
         1:       return '0;
         2:       return exp_id + ID_W'($urandom_range(WINDOW, 48));
         default: return exp_id - ID_W'($urandom_range(1, 24));
      endcase
   endfunction

   // Start from power-on, when no id is expected yet.
   task automatic test_start_and_reset();
      send_packet(ID_W'(5));                 // nonzero id before sync: reset request
      send_request(1'b0, '1, '1, '1);        // all ones, same rule
      send_request(1'b0, '0, '0, '0);        // id zero is the one expected
      send_request(1'b1, '1, '1, '1);        // channel reset ignores the fields
      send_packet('0);
   endtask

   // Expected id is 1 here.
   task automatic test_reorder_window();
      send_packet(ID_W'(3));                 // store ahead
      send_packet(ID_W'(2));
      send_packet(ID_W'(2));                 // already stored: drop
      send_packet(ID_W'(17));                // one past the window: overflow
      send_packet(ID_W'(16));                // last id inside the window
      send_packet(ID_W'(40000));             // more than half the id space away
      send_packet(ID_W'(1));                 // deliver, then drain 2 and 3
      send_packet(ID_W'(2));                 // now behind: drop
   endtask

   // Expected id is 4 here, tolerance off.
   task automatic test_zero_id_rules();
      send_packet('0);                       // unexpected zero: reset request
      set_zero_tolerance(1'b1);
      send_packet('0);                       // tolerated: drop
      set_zero_tolerance(1'b0);
      send_request(1'b1, ID_W'($urandom), TAG_W'($urandom), LEN_W'($urandom));
      send_packet('0);
      send_packet('0);                       // expected id 1: zero is dropped
   endtask

   // Fill every in-window position in reverse order, then send the missing id.
   // One request must then drain the whole store.
   task automatic test_full_window_drain();
      stall_pct = 50;
      send_request(1'b1, '0, '0, '0);
      send_packet('0);
      for (int k = WINDOW; k >= 2; k--) begin
         send_packet(ID_W'(k));
      end
      send_packet(ID_W'(1));
      wait_idle();
      stall_pct = 0;
   endtask

   // Random traffic for one phase, mostly runs of in-window ids.
   task automatic test_random_traffic(input int idle, input int stall, input int items,
                                      input bit tolerance);
      logic [ID_W-1:0] order [$];
      logic [ID_W-1:0] run_id;
      logic [ID_W-1:0] swap_id;
      int sent;
      int n;
      int j;
      set_zero_tolerance(tolerance);
      idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 99) < 4) begin
            send_request(1'b1, ID_W'($urandom), TAG_W'($urandom), LEN_W'($urandom));
            sent++;
         end else if (exp_id == '0) begin
            // Resync with id zero, now and then ask for reset instead.
            if ($urandom_range(0, 3) == 0) begin
               send_packet(ID_W'($urandom_range(1, 65535)));
            end else begin
               send_packet('0);
            end
            sent++;
         end else if ($urandom_range(0, 99) < 12) begin
            send_packet(stray_id());
            sent++;
         end else begin
            // Build a run from the expected id, then scramble it.
            n = $urandom_range(1, WINDOW);
            order.delete();
            run_id = exp_id;
            for (int k = 0; k < n; k++) begin
               order.push_back(run_id);
               run_id = step_id(run_id);
            end
            if ($urandom_range(0, 5) == 0) begin
               for (int k = 0; k < n / 2; k++) begin
                  swap_id = order[k];
                  order[k] = order[n - 1 - k];
                  order[n - 1 - k] = swap_id;
               end
            end else begin
               for (int k = n - 1; k > 0; k--) begin
                  j = $urandom_range(0, k);
                  swap_id = order[k];
                  order[k] = order[j];
                  order[j] = swap_id;
               end
            end
            // Lose one packet now and then so a gap stays in the store.
            if (n > 1 && $urandom_range(0, 5) == 0) begin
               order.delete($urandom_range(0, n - 1));
            end
            foreach (order[pos]) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_packet(stray_id());
                  sent++;
               end
               send_packet(order[pos]);
               sent++;
            end
            // Hold the sender now and then until every response is back.
            if ($urandom_range(0, 11) == 0) begin
               wait_idle();
            end
         end
      end
   endtask

   initial begin
      for (int s = 0; s < WINDOW; s++) begin
         slot_used[s] = 1'b0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_start_and_reset();
      test_reorder_window();
      test_zero_id_rules();
      test_full_window_drain();

      test_random_traffic(0, 0, 80, 1'b0);
      test_random_traffic(83, 0, 80, 1'b1);
      test_random_traffic(0, 83, 80, 1'b0);
      test_random_traffic(33, 33, 80, 1'b1);

      idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      // Let any stray response surface before judging.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sequence_reorder_receiver_core_test OK");
      end else begin
         $display("sequence_reorder_receiver_core_test NOT OK");
      end
      $finish;
   end

endmodule
